// ----- rtl/are_pkg.sv -----
// Shared types and constants for the arithmetic range encoder.
// Used by are_muldiv and arithmetic_range_encoder; depends on nothing.
package are_pkg;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_START  = 2'd1,
    KIND_ENCODE = 2'd2,
    KIND_FLUSH  = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_ZERO_FREQ = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  symbol;
    logic [15:0] frequency;
  } in_item_t;

  typedef struct packed {
    logic        first_bit;
    logic [15:0] follow_count;
    logic        last;
    status_t     status;
  } out_item_t;

  // Main sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CUM_RD,
    S_CUM_ADD,
    S_RD_LO,
    S_RD_HI,
    S_CHK,
    S_MUL_HI,
    S_MUL_LO,
    S_NORM,
    S_FINAL
  } state_t;

  // Multiply/divide unit phases
  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  localparam int unsigned BOUND_W = 32;
  localparam int unsigned RANGE_W = 33;
  localparam int unsigned FOLLOW_W = 16;
  localparam int unsigned RES_CNT_W = 6;

  localparam logic [BOUND_W-1:0] HALF     = 32'h8000_0000;
  localparam logic [BOUND_W-1:0] QUARTER  = 32'h4000_0000;
  localparam logic [BOUND_W-1:0] THREE_Q  = 32'hC000_0000;
  localparam logic [BOUND_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [RES_CNT_W-1:0] MAX_RESULTS = 6'd32;

endpackage

// ----- rtl/are_muldiv.sv -----
// Iterative (a * b) / d unit: shift-add multiply, then restoring division.
// One bit per cycle in each phase. Depends on are_pkg.
module are_muldiv #(
  parameter int unsigned A_W = 33,
  parameter int unsigned B_W = 24,
  parameter int unsigned D_W = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  input  logic [D_W-1:0] d,
  output logic           done,
  output logic [A_W-1:0] q
);

  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned CNT_W = $clog2(P_W + 1);

  are_pkg::md_state_t phase, phase_next;
  logic [P_W-1:0]   acc;
  logic [B_W-1:0]   mult;
  logic [A_W-1:0]   a_reg;
  logic [D_W-1:0]   d_reg;
  logic [D_W:0]     rem;
  logic [CNT_W-1:0] cnt;
  logic [D_W:0]     trial;
  logic             q_bit;

  // Division step: bring down the next dividend bit and try a subtract
  assign trial = {rem[D_W-1:0], acc[P_W-1]};
  assign q_bit = (trial >= {1'b0, d_reg});
  assign q     = acc[A_W-1:0];

  // Phase sequencing
  always_comb begin
    phase_next = phase;
    unique case (phase)
      are_pkg::MD_IDLE: if (start) phase_next = are_pkg::MD_MUL;
      are_pkg::MD_MUL:  if (cnt == CNT_W'(1)) phase_next = are_pkg::MD_DIV;
      are_pkg::MD_DIV:  if (cnt == CNT_W'(1)) phase_next = are_pkg::MD_IDLE;
      default:          phase_next = are_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= are_pkg::MD_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == are_pkg::MD_DIV) && (cnt == CNT_W'(1));
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (phase)
      are_pkg::MD_IDLE: begin
        if (start) begin
          acc   <= '0;
          mult  <= b;
          a_reg <= a;
          d_reg <= d;
          cnt   <= CNT_W'(B_W);
        end
      end
      are_pkg::MD_MUL: begin
        acc  <= {acc[P_W-2:0], 1'b0} + (mult[B_W-1] ? P_W'(a_reg) : '0);
        mult <= {mult[B_W-2:0], 1'b0};
        if (cnt == CNT_W'(1)) begin
          cnt <= CNT_W'(P_W);
          rem <= '0;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
      are_pkg::MD_DIV: begin
        rem <= q_bit ? (trial - {1'b0, d_reg}) : trial;
        acc <= {acc[P_W-2:0], q_bit};
        cnt <= cnt - CNT_W'(1);
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_done_after_div: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(phase) == are_pkg::MD_DIV)
    else $error("done without a division phase");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (phase != are_pkg::MD_IDLE) |-> !start)
    else $error("start while busy");
  a_rem_below_d: assert property (@(posedge clk) disable iff (rst)
    (phase == are_pkg::MD_DIV) |=> (phase != are_pkg::MD_DIV) || (rem < {1'b0, d_reg}))
    else $error("remainder not reduced");
`endif

endmodule

// ----- rtl/arithmetic_range_encoder.sv -----
// Arithmetic encoder, 32-bit interval, static frequency model.
// Depends on are_pkg and are_muldiv.
//
// Input channel (item_valid / item_stall / item): load writes one frequency,
// start builds the cumulative table and opens a message, encode codes one
// symbol, flush closes the message. item_stall is high whenever the
// sequencer is busy; one item is worked on at a time.
// Output channel (result_valid / result_stall / result): each decided bit, up
// to MAX_RESULTS per item, is one result (bit plus count of opposite follow
// bits); last marks the final result of an item. Errors give one result with
// a nonzero status. Start walks every symbol to build the cumulative table;
// an encode reads the two cumulative bounds, makes two passes through the
// shared multiply/divide unit, then renormalizes one shift at a time.
// A stalled result holds the output register; the sequencer waits only when
// it must hand off a result while the register is still full.
// Reset (synchronous, rst high) clears the frequency table valid bits, opens
// an empty model (no total) and empties the output register.
module arithmetic_range_encoder #(
  parameter int unsigned SYMBOLS      = 256,
  parameter int unsigned FREQ_BITS    = 16,
  parameter int unsigned PENDING_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  are_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output are_pkg::out_item_t result
);

  localparam int unsigned SYM_W  = $clog2(SYMBOLS);
  localparam int unsigned CUM_AW = $clog2(SYMBOLS + 1);
  localparam int unsigned CUM_W  = FREQ_BITS + 8;
  localparam int unsigned PEND_W = (PENDING_BITS > 16) ? 16 : PENDING_BITS;
  localparam logic [PEND_W-1:0] PEND_MAX = '1;
  localparam int unsigned BW = are_pkg::BOUND_W;

  are_pkg::state_t state, state_next;

  // Frequency table with valid bits, cumulative table
  logic [FREQ_BITS-1:0] freq_mem [SYMBOLS];
  logic [SYMBOLS-1:0]   fvalid;
  logic [FREQ_BITS-1:0] freq_rdata;
  logic                 fvalid_rd;
  logic                 freq_we;
  logic [CUM_W-1:0]     cum_mem [SYMBOLS+1];
  logic [CUM_W-1:0]     cum_rdata;
  logic [CUM_AW-1:0]    cum_raddr;
  logic                 cum_we;
  logic [CUM_AW-1:0]    cum_waddr;
  logic [CUM_W-1:0]     cum_wdata;

  // Coder state
  logic [BW-1:0]     low;
  logic [BW-1:0]     high;
  logic [PEND_W-1:0] pending;
  logic [CUM_W-1:0]  total;

  // Working registers
  logic [SYM_W-1:0]  idx;
  logic [CUM_W-1:0]  acc_sum;
  logic [SYM_W-1:0]  sym;
  logic [CUM_W-1:0]  cum_lo;
  logic [BW-1:0]     hi_off;
  logic              held_valid;
  logic              held_bit;
  logic [are_pkg::FOLLOW_W-1:0] held_follow;
  are_pkg::status_t  held_status;
  logic              ovf;
  logic [are_pkg::RES_CNT_W-1:0] n_res;

  // Shared multiply/divide unit
  logic                        md_start;
  logic [CUM_W-1:0]            md_b;
  logic                        md_done;
  logic [are_pkg::RANGE_W-1:0] md_q;
  logic [are_pkg::RANGE_W-1:0] range_w;

  logic              accept;
  logic              in_range;
  logic [31:0]       freq_ext;
  logic [CUM_W-1:0]  cum_sum;
  logic              pend_sat;
  logic [PEND_W-1:0] pend_inc;
  logic              out_free;

  // Renormalization step
  logic          nm_e0, nm_e1, nm_mid, nm_done, nm_emit, nm_wait, nm_room;
  logic [BW-1:0] nm_low_sub, nm_high_sub;

  // Output hand-off
  logic                push;
  are_pkg::out_item_t  push_item;
  logic                final_valid;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != are_pkg::S_IDLE);
  assign in_range   = ({1'b0, item.symbol} < 9'(SYMBOLS));
  assign freq_ext   = {16'b0, item.frequency};
  assign cum_sum    = acc_sum + (fvalid_rd ? CUM_W'(freq_rdata) : '0);
  assign pend_sat   = (pending == PEND_MAX);
  assign pend_inc   = pend_sat ? pending : pending + PEND_W'(1);
  assign out_free   = !result_valid || !result_stall;
  assign range_w    = {1'b0, high} - {1'b0, low} + are_pkg::RANGE_W'(1);
  assign md_b       = (state == are_pkg::S_CHK) ? cum_rdata : cum_lo;

  assign nm_e0       = (high < are_pkg::HALF);
  assign nm_e1       = !nm_e0 && (low >= are_pkg::HALF);
  assign nm_mid      = !nm_e0 && !nm_e1 && (low >= are_pkg::QUARTER) &&
                       (high < are_pkg::THREE_Q);
  assign nm_done     = !nm_e0 && !nm_e1 && !nm_mid;
  assign nm_emit     = nm_e0 || nm_e1;
  assign nm_room     = (n_res < are_pkg::MAX_RESULTS);
  assign nm_wait     = nm_emit && held_valid && nm_room && !out_free;
  assign nm_low_sub  = low - (nm_e1 ? are_pkg::HALF : (nm_mid ? are_pkg::QUARTER : '0));
  assign nm_high_sub = high - (nm_e1 ? are_pkg::HALF : (nm_mid ? are_pkg::QUARTER : '0));

  assign final_valid = held_valid || ovf;

  // Result hand-off: a held result leaves when a newer one comes or at the end
  always_comb begin
    push      = 1'b0;
    push_item = '{first_bit: held_bit, follow_count: held_follow, last: 1'b0,
                  status: held_status};
    if (state == are_pkg::S_NORM) begin
      push = !nm_done && !nm_wait && nm_emit && held_valid && nm_room;
    end else if (state == are_pkg::S_FINAL) begin
      push = final_valid && out_free;
      push_item.last = 1'b1;
      if (!held_valid) begin
        push_item.first_bit    = 1'b0;
        push_item.follow_count = '0;
      end
      if (ovf) push_item.status = are_pkg::ST_OVERFLOW;
    end
  end

  // Table write and read addresses
  assign freq_we   = accept && (item.kind == are_pkg::KIND_LOAD) && in_range;
  assign cum_raddr = (state == are_pkg::S_RD_HI) ? CUM_AW'(sym) + CUM_AW'(1)
                                                 : CUM_AW'(sym);
  always_comb begin
    cum_we    = 1'b0;
    cum_waddr = '0;
    cum_wdata = '0;
    if (accept && (item.kind == are_pkg::KIND_START)) begin
      cum_we = 1'b1;
    end else if (state == are_pkg::S_CUM_ADD) begin
      cum_we    = 1'b1;
      cum_waddr = CUM_AW'(idx) + CUM_AW'(1);
      cum_wdata = cum_sum;
    end
  end

  // Memories
  always_ff @(posedge clk) begin
    if (freq_we) freq_mem[item.symbol[SYM_W-1:0]] <= freq_ext[FREQ_BITS-1:0];
    freq_rdata <= freq_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cum_we) cum_mem[cum_waddr] <= cum_wdata;
    cum_rdata <= cum_mem[cum_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= '0;
    end else if (freq_we) begin
      fvalid[item.symbol[SYM_W-1:0]] <= 1'b1;
    end
    fvalid_rd <= fvalid[idx];
  end

  are_muldiv #(
    .A_W(are_pkg::RANGE_W),
    .B_W(CUM_W),
    .D_W(CUM_W)
  ) u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .start(md_start),
    .a    (range_w),
    .b    (md_b),
    .d    (total),
    .done (md_done),
    .q    (md_q)
  );

  // Sequencer next state
  always_comb begin
    state_next = state;
    md_start   = 1'b0;
    unique case (state)
      are_pkg::S_IDLE: begin
        if (accept) begin
          unique case (item.kind)
            are_pkg::KIND_LOAD:   state_next = are_pkg::S_IDLE;
            are_pkg::KIND_START:  state_next = are_pkg::S_CUM_RD;
            are_pkg::KIND_ENCODE: begin
              if (total == '0 || !in_range) state_next = are_pkg::S_FINAL;
              else state_next = are_pkg::S_RD_LO;
            end
            are_pkg::KIND_FLUSH:  state_next = are_pkg::S_FINAL;
          endcase
        end
      end
      are_pkg::S_CUM_RD:  state_next = are_pkg::S_CUM_ADD;
      are_pkg::S_CUM_ADD: begin
        if (idx == SYM_W'(SYMBOLS - 1)) begin
          state_next = (cum_sum == '0) ? are_pkg::S_FINAL : are_pkg::S_IDLE;
        end else begin
          state_next = are_pkg::S_CUM_RD;
        end
      end
      are_pkg::S_RD_LO: state_next = are_pkg::S_RD_HI;
      are_pkg::S_RD_HI: state_next = are_pkg::S_CHK;
      are_pkg::S_CHK: begin
        if (cum_rdata == cum_lo) begin
          state_next = are_pkg::S_FINAL;
        end else begin
          md_start   = 1'b1;
          state_next = are_pkg::S_MUL_HI;
        end
      end
      are_pkg::S_MUL_HI: begin
        if (md_done) begin
          md_start   = 1'b1;
          state_next = are_pkg::S_MUL_LO;
        end
      end
      are_pkg::S_MUL_LO: if (md_done) state_next = are_pkg::S_NORM;
      are_pkg::S_NORM:   if (nm_done) state_next = are_pkg::S_FINAL;
      are_pkg::S_FINAL:  if (!final_valid || out_free) state_next = are_pkg::S_IDLE;
      default:           state_next = are_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= are_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Coder datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      low        <= '0;
      high       <= are_pkg::ALL_ONES;
      pending    <= '0;
      total      <= '0;
      held_valid <= 1'b0;
      ovf        <= 1'b0;
      n_res      <= '0;
    end else begin
      unique case (state)
        are_pkg::S_IDLE: begin
          if (accept) begin
            n_res <= '0;
            ovf   <= 1'b0;
            unique case (item.kind)
              are_pkg::KIND_LOAD: ;
              are_pkg::KIND_START: begin
                idx     <= '0;
                acc_sum <= '0;
              end
              are_pkg::KIND_ENCODE: begin
                sym <= item.symbol[SYM_W-1:0];
                if (total == '0 || !in_range) begin
                  held_valid  <= 1'b1;
                  held_bit    <= 1'b0;
                  held_follow <= '0;
                  held_status <= (total == '0) ? are_pkg::ST_EMPTY : are_pkg::ST_ZERO_FREQ;
                end
              end
              are_pkg::KIND_FLUSH: begin
                held_valid <= 1'b1;
                held_bit   <= 1'b0;
                held_follow <= '0;
                if (total == '0) begin
                  held_status <= are_pkg::ST_EMPTY;
                end else begin
                  held_bit    <= (low >= are_pkg::QUARTER);
                  held_follow <= are_pkg::FOLLOW_W'(pend_inc);
                  held_status <= are_pkg::ST_OK;
                  ovf         <= pend_sat;
                  low         <= '0;
                  high        <= are_pkg::ALL_ONES;
                  pending     <= '0;
                end
              end
            endcase
          end
        end
        are_pkg::S_CUM_RD: ;
        are_pkg::S_CUM_ADD: begin
          acc_sum <= cum_sum;
          idx     <= idx + SYM_W'(1);
          if (idx == SYM_W'(SYMBOLS - 1)) begin
            total   <= cum_sum;
            low     <= '0;
            high    <= are_pkg::ALL_ONES;
            pending <= '0;
            if (cum_sum == '0) begin
              held_valid  <= 1'b1;
              held_bit    <= 1'b0;
              held_follow <= '0;
              held_status <= are_pkg::ST_EMPTY;
            end
          end
        end
        are_pkg::S_RD_LO: ;
        are_pkg::S_RD_HI: cum_lo <= cum_rdata;
        are_pkg::S_CHK: begin
          if (cum_rdata == cum_lo) begin
            held_valid  <= 1'b1;
            held_bit    <= 1'b0;
            held_follow <= '0;
            held_status <= are_pkg::ST_ZERO_FREQ;
          end
        end
        are_pkg::S_MUL_HI: if (md_done) hi_off <= md_q[BW-1:0];
        are_pkg::S_MUL_LO: begin
          if (md_done) begin
            high <= low + hi_off - BW'(1);
            low  <= low + md_q[BW-1:0];
          end
        end
        are_pkg::S_NORM: begin
          if (!nm_done && !nm_wait) begin
            low  <= {nm_low_sub[BW-2:0], 1'b0};
            high <= {nm_high_sub[BW-2:0], 1'b1};
            if (nm_emit) begin
              pending <= '0;
              if (nm_room) begin
                held_valid  <= 1'b1;
                held_bit    <= nm_e1;
                held_follow <= are_pkg::FOLLOW_W'(pending);
                held_status <= are_pkg::ST_OK;
                n_res       <= n_res + are_pkg::RES_CNT_W'(1);
              end
            end else begin
              pending <= pend_inc;
              if (pend_sat) ovf <= 1'b1;
            end
          end
        end
        are_pkg::S_FINAL: begin
          if (!final_valid || out_free) held_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) result <= push_item;
  end

`ifndef ASSERT_OFF
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == are_pkg::S_IDLE) |-> !held_valid)
    else $error("held result left behind in idle");
  a_md_done_state: assert property (@(posedge clk) disable iff (rst)
    md_done |-> (state == are_pkg::S_MUL_HI) || (state == are_pkg::S_MUL_LO))
    else $error("multiply/divide result in wrong state");
  a_res_limit: assert property (@(posedge clk) disable iff (rst)
    n_res <= are_pkg::MAX_RESULTS)
    else $error("result count beyond limit");
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("output register overwritten");
`endif

endmodule
